FILE: src/sphtsm_pkg.sv
package sphtsm_pkg;

	// Field widths
	localparam int DT_W  = 31;
	localparam int DEN_W = 32;
	localparam int NUM_W = 64;

	// Largest step, also "no limit"
	localparam logic [DT_W-1:0] DT_MAX = '1;

	// 1e-6 as a fraction of 2^32
	localparam logic [31:0] SAVE_EPS_Q32 = 32'd4295;

	// Limiter codes
	localparam logic [2:0] LIM_ACCEL  = 3'd0;
	localparam logic [2:0] LIM_CFL    = 3'd1;
	localparam logic [2:0] LIM_ENERGY = 3'd2;
	localparam logic [2:0] LIM_SMOOTH = 3'd3;
	localparam logic [2:0] LIM_SAVE   = 3'd4;

	// Register indexes
	typedef enum logic [1:0] {
		CFG_GAMMA   = 2'd0,
		CFG_COURANT = 2'd1,
		CFG_SAVE    = 2'd2,
		CFG_TIME    = 2'd3
	} sphtsm_cfg_idx_t;

	typedef struct packed {
		logic [DT_W-1:0] adiabatic_index;
		logic [DT_W-1:0] courant_factor;
		logic [DT_W-1:0] save_interval;
		logic [DT_W-1:0] current_time;
	} sphtsm_cfg_t;

	typedef struct packed {
		logic signed [31:0] accel_x;
		logic signed [31:0] accel_y;
		logic signed [31:0] accel_z;
		logic [DT_W-1:0]    smoothing_len;
		logic [DT_W-1:0]    energy;
		logic signed [31:0] energy_rate;
		logic signed [31:0] smoothing_rate;
		logic [DT_W-1:0]    pressure;
		logic [DT_W-1:0]    density;
		logic               last_particle;
	} sphtsm_in_t;

	typedef struct packed {
		logic [DT_W-1:0] dt_accel;
		logic [DT_W-1:0] dt_energy;
		logic [DT_W-1:0] dt_smoothing;
		logic [DT_W-1:0] dt_cfl;
		logic [DT_W-1:0] dt_save;
		logic [DT_W-1:0] dt_global;
		logic [2:0]      limiter;
	} sphtsm_out_t;

	// Classified particle as queued between front and back
	typedef struct packed {
		logic [31:0]     ax_mag;
		logic [31:0]     ay_mag;
		logic [31:0]     az_mag;
		logic [DT_W-1:0] h;
		logic [DT_W-1:0] u;
		logic [31:0]     dudt_mag;
		logic            cooling;
		logic [31:0]     dhdt_mag;
		logic            dh_nz;
		logic [DT_W-1:0] p;
		logic [DT_W-1:0] rho;
		logic            last;
	} sphtsm_item_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_SQ_X,
		ST_SQ_Y,
		ST_SQ_Z,
		ST_SQ_SUM,
		ST_PG,
		ST_A_ROOT,
		ST_A_DIV,
		ST_A_ROOT2,
		ST_E_DIV,
		ST_H_DIV,
		ST_C_DIV,
		ST_C_ROOT,
		ST_C_DIV2,
		ST_F_SMOOTH,
		ST_F_CFL,
		ST_F_EPS,
		ST_F_KDIV,
		ST_F_KS,
		ST_F_SAVE,
		ST_OUT
	} sphtsm_state_t;

	function automatic logic [DT_W-1:0] sat31(input logic [63:0] x);
		return (x > 64'(DT_MAX)) ? DT_MAX : x[DT_W-1:0];
	endfunction

	function automatic logic [31:0] mag32(input logic [31:0] v);
		return v[31] ? (32'd0 - v) : v;
	endfunction

endpackage

FILE: src/sph_timestep_min_reduction_top.sv
// Per particle, the back end runs each active criterion in turn; with all four active
// it uses three square roots and five divides on the single shared 32-step divider
// and 32-step square-root unit. The last word of a batch adds scaling and the
// save-time divide before its result is registered for output.
// A two-word queue lets input words be taken while the back end works.
// Reset (arst_n low, asynchronous): registers to defaults, minima to no limit, queue empty.
module sph_timestep_min_reduction_top import sphtsm_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  sphtsm_in_t  in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output sphtsm_out_t out_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [30:0] cfg_data
);

	sphtsm_cfg_t  cfg_q;
	logic         item_valid;
	logic         item_pop;
	sphtsm_item_t item;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.adiabatic_index <= 31'd91750;
			cfg_q.courant_factor  <= 31'd19661;
			cfg_q.save_interval   <= 31'd655360;
			cfg_q.current_time    <= 31'd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (sphtsm_cfg_idx_t'(cfg_index))
				CFG_GAMMA:   cfg_q.adiabatic_index <= cfg_data;
				CFG_COURANT: cfg_q.courant_factor  <= cfg_data;
				CFG_SAVE:    cfg_q.save_interval   <= cfg_data;
				CFG_TIME:    cfg_q.current_time    <= cfg_data;
			endcase
		end
	end

	sphtsm_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.in_data(in_data), .item_valid(item_valid), .item_pop(item_pop), .item(item)
	);

	sphtsm_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .item_valid(item_valid), .item_pop(item_pop),
		.item(item), .cfg(cfg_q), .out_valid(out_valid), .out_ready(out_ready),
		.out_data(out_data)
	);

endmodule

FILE: src/sphtsm_front.sv
module sphtsm_front import sphtsm_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  sphtsm_in_t   in_data,
	output logic         item_valid,
	input  logic         item_pop,
	output sphtsm_item_t item
);

	sphtsm_item_t mem_q [2];
	logic         wr_ptr_q;
	logic         rd_ptr_q;
	logic [1:0]   count_q;
	sphtsm_item_t cls;
	logic         push;

	// Classify: magnitudes and flags for the back end
	always_comb begin
		cls.ax_mag   = mag32(in_data.accel_x);
		cls.ay_mag   = mag32(in_data.accel_y);
		cls.az_mag   = mag32(in_data.accel_z);
		cls.h        = in_data.smoothing_len;
		cls.u        = in_data.energy;
		cls.dudt_mag = mag32(in_data.energy_rate);
		cls.cooling  = in_data.energy_rate[31];
		cls.dhdt_mag = mag32(in_data.smoothing_rate);
		cls.dh_nz    = (in_data.smoothing_rate != '0);
		cls.p        = in_data.pressure;
		cls.rho      = in_data.density;
		cls.last     = in_data.last_particle;
	end

	assign in_ready   = (count_q != 2'd2);
	assign push       = in_valid & in_ready;
	assign item_valid = (count_q != 2'd0);
	assign item       = mem_q[rd_ptr_q];

	// Two-entry queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (item_pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(item_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= cls;
	end

endmodule

FILE: src/sphtsm_div.sv
module sphtsm_div import sphtsm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic             done,
	output logic [DEN_W-1:0] quo
);

	logic [DEN_W-1:0] r_q;
	logic [31:0]      n_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] quo_q;
	logic [4:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   r_n;
	logic             fits;
	logic             overflow;

	// Quotient would not fit 32 bits (also zero divisor)
	assign overflow = (num >= {den, 32'd0});
	assign r_n      = {r_q, n_q[31]};
	assign fits     = (r_n >= {1'b0, den_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= !overflow;
				done_q <= overflow;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Restoring division, one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			r_q   <= num[63:32];
			n_q   <= num[31:0];
			den_q <= den;
			quo_q <= overflow ? '1 : '0;
		end else if (busy_q) begin
			r_q   <= fits ? DEN_W'(r_n - {1'b0, den_q}) : r_n[DEN_W-1:0];
			n_q   <= {n_q[30:0], 1'b0};
			quo_q <= {quo_q[DEN_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

FILE: src/sphtsm_sqrt.sv
module sphtsm_sqrt import sphtsm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [NUM_W-1:0] rad,
	output logic             done,
	output logic [31:0]      root
);

	logic [NUM_W-1:0] x_q;
	logic [35:0]      rem_q;
	logic [31:0]      root_q;
	logic [4:0]       cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [35:0]      rem_n;
	logic [35:0]      trial;
	logic             take;

	assign rem_n = {rem_q[33:0], x_q[63:62]};
	assign trial = {2'b00, root_q, 2'b01};
	assign take  = (rem_n >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Digit-by-digit root, one bit a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q    <= {x_q[61:0], 2'b00};
			rem_q  <= take ? (rem_n - trial) : rem_n;
			root_q <= {root_q[30:0], take};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

FILE: src/sphtsm_back.sv
module sphtsm_back import sphtsm_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         item_valid,
	output logic         item_pop,
	input  sphtsm_item_t item,
	input  sphtsm_cfg_t  cfg,
	output logic         out_valid,
	input  logic         out_ready,
	output sphtsm_out_t  out_data
);

	localparam logic [31:0] SCALE_015 = 32'(((15 << FRAC_BITS) + 50) / 100);

	sphtsm_state_t   state_q, state_d;
	sphtsm_item_t    it_q;
	logic            go_q;
	logic [63:0]     prod_q;
	logic [63:0]     a2_q;
	logic [63:0]     pg_q;
	logic [DT_W-1:0] tmp_q;
	logic [31:0]     den_q;
	logic [DT_W-1:0] min_acc_q, min_eng_q, min_smo_q, min_cfl_q;
	logic [DT_W-1:0] dth_q, dtc_q, dts_q;
	logic            out_valid_q;
	sphtsm_out_t     out_q;

	logic [31:0]      mul_a, mul_b;
	logic             div_start, div_done;
	logic [NUM_W-1:0] div_num;
	logic [DEN_W-1:0] div_den, div_quo;
	logic             sqrt_start, sqrt_done;
	logic [NUM_W-1:0] sqrt_rad;
	logic [31:0]      sqrt_root;
	logic [DT_W-1:0]  div_sat, root_sat, s_eff;
	logic [63:0]      h_sh, tmp_sh;
	logic             out_free;
	sphtsm_state_t    after_a, after_e, after_h, after_c;
	sphtsm_out_t      res;

	sphtsm_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num),
		.den(div_den), .done(div_done), .quo(div_quo)
	);

	sphtsm_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sqrt_start), .rad(sqrt_rad),
		.done(sqrt_done), .root(sqrt_root)
	);

	assign div_sat  = sat31({32'd0, div_quo});
	assign root_sat = sat31({32'd0, sqrt_root});
	assign s_eff    = (cfg.save_interval == '0) ? DT_W'(1) : cfg.save_interval;
	assign h_sh     = 64'(it_q.h) << FRAC_BITS;
	assign tmp_sh   = 64'(tmp_q) << FRAC_BITS;
	assign out_free = !out_valid_q || out_ready;

	// Which criterion comes next
	always_comb begin
		after_c = it_q.last ? ST_F_SMOOTH : ST_IDLE;
		after_h = (it_q.rho != '0) ? ST_C_DIV : after_c;
		after_e = it_q.dh_nz ? ST_H_DIV : after_h;
		after_a = it_q.cooling ? ST_E_DIV : after_e;
	end

	// Sequencer: next state, unit starts, multiplier operands
	always_comb begin
		state_d    = state_q;
		item_pop   = 1'b0;
		div_start  = 1'b0;
		sqrt_start = 1'b0;
		mul_a      = '0;
		mul_b      = '0;
		div_num    = '0;
		div_den    = '0;
		sqrt_rad   = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					item_pop = 1'b1;
					state_d  = ST_SQ_X;
				end
			end
			ST_SQ_X: begin
				mul_a   = it_q.ax_mag;
				mul_b   = it_q.ax_mag;
				state_d = ST_SQ_Y;
			end
			ST_SQ_Y: begin
				mul_a   = it_q.ay_mag;
				mul_b   = it_q.ay_mag;
				state_d = ST_SQ_Z;
			end
			ST_SQ_Z: begin
				mul_a   = it_q.az_mag;
				mul_b   = it_q.az_mag;
				state_d = ST_SQ_SUM;
			end
			ST_SQ_SUM: begin
				mul_a   = 32'(it_q.p);
				mul_b   = 32'(cfg.adiabatic_index);
				state_d = ST_PG;
			end
			ST_PG: begin
				state_d = (a2_q != '0) ? ST_A_ROOT : after_a;
			end
			ST_A_ROOT: begin
				sqrt_rad   = a2_q;
				sqrt_start = !go_q;
				if (sqrt_done) state_d = ST_A_DIV;
			end
			ST_A_DIV: begin
				div_num   = h_sh;
				div_den   = den_q;
				div_start = !go_q;
				if (div_done) state_d = ST_A_ROOT2;
			end
			ST_A_ROOT2: begin
				sqrt_rad   = tmp_sh;
				sqrt_start = !go_q;
				if (sqrt_done) state_d = after_a;
			end
			ST_E_DIV: begin
				div_num   = 64'(it_q.u) << FRAC_BITS;
				div_den   = it_q.dudt_mag;
				div_start = !go_q;
				if (div_done) state_d = after_e;
			end
			ST_H_DIV: begin
				div_num   = h_sh;
				div_den   = it_q.dhdt_mag;
				div_start = !go_q;
				if (div_done) state_d = after_h;
			end
			ST_C_DIV: begin
				div_num   = pg_q;
				div_den   = 32'(it_q.rho);
				div_start = !go_q;
				if (div_done) state_d = ST_C_ROOT;
			end
			ST_C_ROOT: begin
				sqrt_rad   = tmp_sh;
				sqrt_start = !go_q;
				if (sqrt_done) state_d = (sqrt_root != '0) ? ST_C_DIV2 : after_c;
			end
			ST_C_DIV2: begin
				div_num   = h_sh;
				div_den   = den_q;
				div_start = !go_q;
				if (div_done) state_d = after_c;
			end
			ST_F_SMOOTH: begin
				mul_a   = 32'(min_smo_q);
				mul_b   = SCALE_015;
				state_d = ST_F_CFL;
			end
			ST_F_CFL: begin
				mul_a   = 32'(min_cfl_q);
				mul_b   = 32'(cfg.courant_factor);
				state_d = ST_F_EPS;
			end
			ST_F_EPS: begin
				mul_a   = 32'(s_eff);
				mul_b   = SAVE_EPS_Q32;
				state_d = ST_F_KDIV;
			end
			ST_F_KDIV: begin
				div_num   = 64'(cfg.current_time) + (prod_q >> 32);
				div_den   = 32'(s_eff);
				div_start = !go_q;
				if (div_done) state_d = ST_F_KS;
			end
			ST_F_KS: begin
				mul_a   = den_q;
				mul_b   = 32'(s_eff);
				state_d = ST_F_SAVE;
			end
			ST_F_SAVE: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Final scaling, global minimum and limiter
	always_comb begin
		res.dt_accel     = (min_acc_q == DT_MAX) ? DT_MAX : (min_acc_q >> 1);
		res.dt_energy    = min_eng_q;
		res.dt_smoothing = dth_q;
		res.dt_cfl       = dtc_q;
		res.dt_save      = dts_q;
		res.dt_global    = res.dt_accel;
		res.limiter      = LIM_ACCEL;
		if (dtc_q < res.dt_global) begin
			res.dt_global = dtc_q;
			res.limiter   = LIM_CFL;
		end
		if (min_eng_q < res.dt_global) begin
			res.dt_global = min_eng_q;
			res.limiter   = LIM_ENERGY;
		end
		if (dth_q < res.dt_global) begin
			res.dt_global = dth_q;
			res.limiter   = LIM_SMOOTH;
		end
		if (dts_q < res.dt_global) begin
			res.dt_global = dts_q;
			res.limiter   = LIM_SAVE;
		end
	end

	// Control state, running minima, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			go_q        <= 1'b0;
			out_valid_q <= 1'b0;
			min_acc_q   <= DT_MAX;
			min_eng_q   <= DT_MAX;
			min_smo_q   <= DT_MAX;
			min_cfl_q   <= DT_MAX;
		end else begin
			state_q <= state_d;
			if (div_start || sqrt_start) go_q <= 1'b1;
			else if (div_done || sqrt_done) go_q <= 1'b0;

			if (state_q == ST_OUT && out_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;

			if (state_q == ST_A_ROOT2 && sqrt_done && root_sat < min_acc_q)
				min_acc_q <= root_sat;
			if (state_q == ST_E_DIV && div_done && div_sat < min_eng_q)
				min_eng_q <= div_sat;
			if (state_q == ST_H_DIV && div_done && div_sat != '0 && div_sat < min_smo_q)
				min_smo_q <= div_sat;
			if (state_q == ST_C_DIV2 && div_done && div_sat < min_cfl_q)
				min_cfl_q <= div_sat;

			// batch closed: minima back to no limit
			if (state_q == ST_OUT && out_free) begin
				min_acc_q <= DT_MAX;
				min_eng_q <= DT_MAX;
				min_smo_q <= DT_MAX;
				min_cfl_q <= DT_MAX;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		prod_q <= 64'(mul_a) * 64'(mul_b);
		if (item_pop) it_q <= item;
		unique case (state_q)
			ST_SQ_Y:   a2_q <= prod_q;
			ST_SQ_Z:   a2_q <= a2_q + prod_q;
			ST_SQ_SUM: a2_q <= a2_q + prod_q;
			ST_PG:     pg_q <= prod_q;
			ST_A_ROOT: if (sqrt_done) den_q <= sqrt_root;
			ST_A_DIV:  if (div_done) tmp_q <= div_sat;
			ST_C_DIV:  if (div_done) tmp_q <= div_sat;
			ST_C_ROOT: if (sqrt_done) den_q <= sqrt_root;
			ST_F_CFL:  dth_q <= (min_smo_q == DT_MAX) ? DT_MAX : sat31(prod_q >> FRAC_BITS);
			ST_F_EPS:  dtc_q <= (min_cfl_q == DT_MAX) ? DT_MAX : sat31(prod_q >> FRAC_BITS);
			ST_F_KDIV: if (div_done) den_q <= div_quo;
			ST_F_SAVE: dts_q <= sat31(prod_q + 64'(s_eff) - 64'(cfg.current_time));
			ST_OUT:    if (out_free) out_q <= res;
			default:   ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
